### rtl/ahb_to_apb_bridge_fsm_core_assert.svh
// assertion helpers for the ahb to apb bridge
`ifndef AHB_TO_APB_BRIDGE_FSM_CORE_ASSERT_SVH
`define AHB_TO_APB_BRIDGE_FSM_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AHB_APB_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ahb_apb same-cycle check failed");

// next-cycle implication, checked outside reset
`define AHB_APB_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ahb_apb next-cycle check failed");

`endif

### rtl/ahb_apb_pkg.sv
`timescale 1ns / 1ps

package ahb_apb_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int ADDR_W         = 32;
  localparam int STATE_W        = 3;
  localparam int SEL_W          = 3;

  // bridge states
  localparam logic [STATE_W-1:0] ST_IDLE           = 3'd0;
  localparam logic [STATE_W-1:0] ST_WR_WAIT        = 3'd1;
  localparam logic [STATE_W-1:0] ST_READ           = 3'd2;
  localparam logic [STATE_W-1:0] ST_WR_SETUP       = 3'd3;
  localparam logic [STATE_W-1:0] ST_WR_SETUP_PIPE  = 3'd4;
  localparam logic [STATE_W-1:0] ST_RD_ACCESS      = 3'd5;
  localparam logic [STATE_W-1:0] ST_WR_ACCESS      = 3'd6;
  localparam logic [STATE_W-1:0] ST_WR_ACCESS_PIPE = 3'd7;

  // address map
  localparam logic [ADDR_W-1:0] SLV0_BASE = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] SLV1_BASE = 32'h8400_0000;
  localparam logic [ADDR_W-1:0] SLV2_BASE = 32'h8800_0000;
  localparam logic [ADDR_W-1:0] WIN_TOP   = 32'h8C00_0000;

  localparam logic [SEL_W-1:0] SEL_NONE = 3'b000;
  localparam logic [SEL_W-1:0] SEL_S0   = 3'b001;
  localparam logic [SEL_W-1:0] SEL_S1   = 3'b010;
  localparam logic [SEL_W-1:0] SEL_S2   = 3'b100;

  localparam logic [1:0] HTRANS_NONSEQ = 2'h2;
  localparam logic [1:0] HTRANS_SEQ    = 2'h3;

  localparam logic RESP_OKAY = 1'b0;

  typedef struct packed {
    logic             write;
    logic             enable;
    logic [SEL_W-1:0] select;
    logic             ready;
  } apb_ctrl_t;

  localparam int CTRL_W = $bits(apb_ctrl_t);

endpackage

### rtl/ahb_apb_in_reg.sv
`timescale 1ns / 1ps

module ahb_apb_in_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         stage_valid,
  output logic [W-1:0] stage_data,
  input  logic         stage_take
);

  logic         valid;
  logic [W-1:0] data;

  assign in_ready    = !valid || stage_take;
  assign stage_valid = valid;
  assign stage_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (stage_take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

### rtl/ahb_apb_core.sv
`timescale 1ns / 1ps

module ahb_apb_core #(
  parameter int DATA_WIDTH = ahb_apb_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           bus_reset_n,
  input  logic                           ready_in,
  input  logic [ahb_apb_pkg::ADDR_W-1:0] address,
  input  logic [1:0]                     transfer_type,
  input  logic                           write_enable,
  input  logic [DATA_WIDTH-1:0]          write_data,
  input  logic [DATA_WIDTH-1:0]          peripheral_read_data,
  output logic [ahb_apb_pkg::ADDR_W-1:0] res_address,
  output logic [DATA_WIDTH-1:0]          res_write_data,
  output ahb_apb_pkg::apb_ctrl_t         res_ctrl,
  output logic [DATA_WIDTH-1:0]          res_read_data
);

  // stored state
  logic [ahb_apb_pkg::STATE_W-1:0] state;
  logic [ahb_apb_pkg::ADDR_W-1:0]  addr_s1;
  logic [DATA_WIDTH-1:0]           data_s1;
  logic [ahb_apb_pkg::ADDR_W-1:0]  held_address;
  logic [DATA_WIDTH-1:0]           held_write_data;
  ahb_apb_pkg::apb_ctrl_t          held_ctrl;

  // next values
  logic [ahb_apb_pkg::STATE_W-1:0] cur_state, state_next;
  logic [ahb_apb_pkg::ADDR_W-1:0]  addr_s1_next, addr_s2_next;
  logic [DATA_WIDTH-1:0]           data_s1_next, data_s2_next;
  logic                            wflag_next;
  logic [ahb_apb_pkg::ADDR_W-1:0]  held_address_next;
  logic [DATA_WIDTH-1:0]           held_write_data_next;
  ahb_apb_pkg::apb_ctrl_t          held_ctrl_next;
  logic                            xfer_valid;
  logic                            in_window;
  logic [ahb_apb_pkg::SEL_W-1:0]   sel;

  assign res_address    = bus_reset_n ? held_address : '0;
  assign res_write_data = bus_reset_n ? held_write_data : '0;
  assign res_ctrl       = bus_reset_n ? held_ctrl : '0;
  assign res_read_data  = bus_reset_n ? peripheral_read_data : '0;

  always_comb begin
    cur_state    = bus_reset_n ? state : ahb_apb_pkg::ST_IDLE;
    addr_s1_next = bus_reset_n ? address : '0;
    addr_s2_next = bus_reset_n ? addr_s1 : '0;
    data_s1_next = bus_reset_n ? write_data : '0;
    data_s2_next = bus_reset_n ? data_s1 : '0;
    wflag_next   = bus_reset_n && write_enable;

    in_window  = (address >= ahb_apb_pkg::SLV0_BASE) && (address <= ahb_apb_pkg::WIN_TOP);
    xfer_valid = bus_reset_n && ready_in && in_window &&
                 (transfer_type == ahb_apb_pkg::HTRANS_NONSEQ ||
                  transfer_type == ahb_apb_pkg::HTRANS_SEQ);

    sel = ahb_apb_pkg::SEL_NONE;
    if (bus_reset_n) begin
      if (address >= ahb_apb_pkg::SLV0_BASE && address < ahb_apb_pkg::SLV1_BASE) begin
        sel = ahb_apb_pkg::SEL_S0;
      end else if (address >= ahb_apb_pkg::SLV1_BASE && address < ahb_apb_pkg::SLV2_BASE) begin
        sel = ahb_apb_pkg::SEL_S1;
      end else if (address >= ahb_apb_pkg::SLV2_BASE && address < ahb_apb_pkg::WIN_TOP) begin
        sel = ahb_apb_pkg::SEL_S2;
      end
    end

    case (cur_state)
      ahb_apb_pkg::ST_IDLE, ahb_apb_pkg::ST_RD_ACCESS: begin
        state_next = !xfer_valid ? ahb_apb_pkg::ST_IDLE :
                     (write_enable ? ahb_apb_pkg::ST_WR_WAIT : ahb_apb_pkg::ST_READ);
      end
      ahb_apb_pkg::ST_WR_WAIT: begin
        state_next = xfer_valid ? ahb_apb_pkg::ST_WR_SETUP_PIPE : ahb_apb_pkg::ST_WR_SETUP;
      end
      ahb_apb_pkg::ST_READ:   state_next = ahb_apb_pkg::ST_RD_ACCESS;
      ahb_apb_pkg::ST_WR_SETUP: begin
        state_next = xfer_valid ? ahb_apb_pkg::ST_WR_ACCESS_PIPE : ahb_apb_pkg::ST_WR_ACCESS;
      end
      ahb_apb_pkg::ST_WR_SETUP_PIPE: state_next = ahb_apb_pkg::ST_WR_ACCESS;
      ahb_apb_pkg::ST_WR_ACCESS: begin
        state_next = ready_in ? ahb_apb_pkg::ST_IDLE : ahb_apb_pkg::ST_WR_WAIT;
      end
      default: begin
        if (!xfer_valid && wflag_next) begin
          state_next = ahb_apb_pkg::ST_WR_SETUP;
        end else if (xfer_valid && !wflag_next) begin
          state_next = ahb_apb_pkg::ST_WR_SETUP_PIPE;
        end else begin
          state_next = ahb_apb_pkg::ST_READ;
        end
      end
    endcase

    held_address_next    = held_address;
    held_write_data_next = held_write_data;
    held_ctrl_next       = held_ctrl;
    case (cur_state)
      ahb_apb_pkg::ST_IDLE, ahb_apb_pkg::ST_RD_ACCESS: begin
        if (xfer_valid && !write_enable) begin
          held_address_next     = address;
          held_ctrl_next.write  = write_enable;
          held_ctrl_next.select = sel;
          held_ctrl_next.enable = 1'b0;
          held_ctrl_next.ready  = 1'b0;
        end else begin
          // idle drops the address, read-enable drops the select
          if (cur_state == ahb_apb_pkg::ST_IDLE) begin
            held_address_next = '0;
          end else begin
            held_ctrl_next.select = ahb_apb_pkg::SEL_NONE;
          end
          held_ctrl_next.enable = 1'b0;
          held_ctrl_next.ready  = 1'b1;
        end
      end
      ahb_apb_pkg::ST_WR_WAIT: begin
        held_address_next     = addr_s1_next;
        held_ctrl_next.write  = 1'b1;
        held_ctrl_next.select = sel;
        held_ctrl_next.enable = 1'b0;
        held_ctrl_next.ready  = 1'b0;
        held_write_data_next  = xfer_valid ? data_s1_next : write_data;
      end
      ahb_apb_pkg::ST_READ, ahb_apb_pkg::ST_WR_SETUP_PIPE: begin
        held_ctrl_next.enable = 1'b1;
        held_ctrl_next.ready  = 1'b1;
      end
      ahb_apb_pkg::ST_WR_ACCESS_PIPE: begin
        held_address_next     = addr_s2_next;
        held_ctrl_next.write  = write_enable;
        held_ctrl_next.select = sel;
        held_ctrl_next.enable = 1'b0;
        if (!xfer_valid && wflag_next) begin
          held_write_data_next = write_data;
          held_ctrl_next.ready = 1'b0;
        end else begin
          held_write_data_next = data_s2_next;
          held_ctrl_next.ready = 1'b1;
        end
      end
      ahb_apb_pkg::ST_WR_ACCESS: begin
        if (!xfer_valid && wflag_next) begin
          held_address_next = '0;
        end else begin
          held_ctrl_next.select = ahb_apb_pkg::SEL_NONE;
        end
        held_ctrl_next.enable = 1'b0;
        held_ctrl_next.ready  = 1'b0;
      end
      default: begin
        // write state holds everything
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ahb_apb_pkg::ST_IDLE;
      addr_s1         <= '0;
      data_s1         <= '0;
      held_address    <= '0;
      held_write_data <= '0;
      held_ctrl       <= '0;
    end else if (step) begin
      state           <= state_next;
      addr_s1         <= addr_s1_next;
      data_s1         <= data_s1_next;
      held_address    <= held_address_next;
      held_write_data <= held_write_data_next;
      held_ctrl       <= held_ctrl_next;
    end
  end

endmodule

### rtl/ahb_apb_out_buf.sv
`timescale 1ns / 1ps

module ahb_apb_out_buf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/ahb_to_apb_bridge_fsm_core.sv
`timescale 1ns / 1ps
// ahb to apb bridge, cycle model driven one bus clock per transaction
// input channel (in_valid/in_ready): one transaction is one bus clock worth of
//   ahb master signals plus the apb read data sampled in that clock
// output channel (out_valid/out_ready): one transaction per input, carrying
//   the registered apb address, write data, direction, enable, select,
//   ahb ready, passed-through read data and an always-okay response
// path: a transaction lands in the input register on acceptance, is evaluated
//   against the bridge fsm and its two-stage address/data pipe once the output
//   buffer has room, and its result is registered there before being offered
// throughput: one transaction per cycle while the output buffer has room
// stall: a two-entry output buffer keeps accepting while a result waits; the
//   input backs up only once both entries and the input register are full
// reset (rst): clears the fsm to idle, the pipeline, the held apb values and
//   all channel valids; bus_reset_n low inside a transaction clears the fsm
//   and pipe for that clock and returns an all-zero result

`include "ahb_to_apb_bridge_fsm_core_assert.svh"

module ahb_to_apb_bridge_fsm_core #(
  parameter int DATA_WIDTH = ahb_apb_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input transaction channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           bus_reset_n,
  input  logic                           ready_in,
  input  logic [ahb_apb_pkg::ADDR_W-1:0] address,
  input  logic [1:0]                     transfer_type,
  input  logic                           write_enable,
  input  logic [DATA_WIDTH-1:0]          write_data,
  input  logic [DATA_WIDTH-1:0]          peripheral_read_data,
  // result transaction channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ahb_apb_pkg::ADDR_W-1:0] apb_address,
  output logic [DATA_WIDTH-1:0]          apb_write_data,
  output logic                           apb_write,
  output logic                           apb_enable,
  output logic [ahb_apb_pkg::SEL_W-1:0]  apb_select,
  output logic                           ready_out,
  output logic [DATA_WIDTH-1:0]          read_data,
  output logic                           response
);

  // input item: reset, ready, address, htrans, write, wdata, rdata
  localparam int ITEM_W = 1 + 1 + ahb_apb_pkg::ADDR_W + 2 + 1 + 2 * DATA_WIDTH;
  // result item: address, wdata, control group, rdata
  localparam int RES_W  = ahb_apb_pkg::ADDR_W + 2 * DATA_WIDTH + ahb_apb_pkg::CTRL_W;

  logic                           stage_valid;
  logic [ITEM_W-1:0]              stage_data;
  logic                           step;
  logic                           buf_full;

  logic                           s_bus_reset_n;
  logic                           s_ready_in;
  logic [ahb_apb_pkg::ADDR_W-1:0] s_address;
  logic [1:0]                     s_transfer_type;
  logic                           s_write_enable;
  logic [DATA_WIDTH-1:0]          s_write_data;
  logic [DATA_WIDTH-1:0]          s_read_data;

  logic [ahb_apb_pkg::ADDR_W-1:0] res_address;
  logic [DATA_WIDTH-1:0]          res_write_data;
  ahb_apb_pkg::apb_ctrl_t         res_ctrl;
  logic [DATA_WIDTH-1:0]          res_read_data;
  ahb_apb_pkg::apb_ctrl_t         out_ctrl;
  logic [RES_W-1:0]               buf_out;

  // input register: lets the upstream side run one transaction ahead
  ahb_apb_in_reg #(
    .W (ITEM_W)
  ) u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     ({bus_reset_n, ready_in, address, transfer_type, write_enable,
                   write_data, peripheral_read_data}),
    .stage_valid (stage_valid),
    .stage_data  (stage_data),
    .stage_take  (step)
  );

  assign {s_bus_reset_n, s_ready_in, s_address, s_transfer_type, s_write_enable,
          s_write_data, s_read_data} = stage_data;

  // a transaction is evaluated whenever the output buffer has room
  assign step = stage_valid && !buf_full;

  ahb_apb_core #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk                  (clk),
    .rst                  (rst),
    .step                 (step),
    .bus_reset_n          (s_bus_reset_n),
    .ready_in             (s_ready_in),
    .address              (s_address),
    .transfer_type        (s_transfer_type),
    .write_enable         (s_write_enable),
    .write_data           (s_write_data),
    .peripheral_read_data (s_read_data),
    .res_address          (res_address),
    .res_write_data       (res_write_data),
    .res_ctrl             (res_ctrl),
    .res_read_data        (res_read_data)
  );

  // two-entry result buffer decouples the receiver stall from the fsm
  ahb_apb_out_buf #(
    .W (RES_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data ({res_address, res_write_data, res_ctrl, res_read_data}),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (buf_out)
  );

  assign {apb_address, apb_write_data, out_ctrl, read_data} = buf_out;
  assign apb_write  = out_ctrl.write;
  assign apb_enable = out_ctrl.enable;
  assign apb_select = out_ctrl.select;
  assign ready_out  = out_ctrl.ready;
  // the bridge never signals an error
  assign response   = ahb_apb_pkg::RESP_OKAY;

  // slave select is one-hot or none on every result
  `AHB_APB_CHECK_NOW(a_select_onehot, out_valid, $onehot0(apb_select))
  // an empty result buffer never backpressures the input
  `AHB_APB_CHECK_NOW(a_empty_takes_input, !out_valid, in_ready)
  // a bus-reset clock yields an all-zero control group
  `AHB_APB_CHECK_NOW(a_bus_reset_zero, step && !s_bus_reset_n,
                     res_ctrl == '0 && res_address == '0)
  // an evaluated transaction always leaves out_valid high in the next cycle
  `AHB_APB_CHECK_NEXT(a_step_gives_result, step, out_valid)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ahb_apb_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int RAND_TXNS   = 1950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_START  = 420;

  // one bus clock worth of ahb master signals plus apb read data
  typedef struct {
    logic          bus_reset_n;
    logic          ready_in;
    logic [31:0]   address;
    logic [1:0]    transfer_type;
    logic          write_enable;
    logic [DW-1:0] write_data;
    logic [DW-1:0] peripheral_read_data;
  } bridge_txn_t;

  typedef struct {
    logic [31:0]      apb_address;
    logic [DW-1:0]    apb_write_data;
    logic             apb_write;
    logic             apb_enable;
    logic [SEL_W-1:0] apb_select;
    logic             ready_out;
    logic [DW-1:0]    read_data;
    logic             response;
  } bridge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid             = 1'b0;
  logic                in_ready;
  logic                bus_reset_n          = 1'b0;
  logic                ready_in             = 1'b0;
  logic [ADDR_W-1:0]   address              = '0;
  logic [1:0]          transfer_type        = '0;
  logic                write_enable         = 1'b0;
  logic [DW-1:0]       write_data           = '0;
  logic [DW-1:0]       peripheral_read_data = '0;
  logic                out_valid;
  logic                out_ready            = 1'b0;
  logic [ADDR_W-1:0]   apb_address;
  logic [DW-1:0]       apb_write_data;
  logic                apb_write;
  logic                apb_enable;
  logic [SEL_W-1:0]    apb_select;
  logic                ready_out;
  logic [DW-1:0]       read_data;
  logic                response;

  ahb_to_apb_bridge_fsm_core #(.DATA_WIDTH(DW)) u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .bus_reset_n          (bus_reset_n),
    .ready_in             (ready_in),
    .address              (address),
    .transfer_type        (transfer_type),
    .write_enable         (write_enable),
    .write_data           (write_data),
    .peripheral_read_data (peripheral_read_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .apb_address          (apb_address),
    .apb_write_data       (apb_write_data),
    .apb_write            (apb_write),
    .apb_enable           (apb_enable),
    .apb_select           (apb_select),
    .ready_out            (ready_out),
    .read_data            (read_data),
    .response             (response)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // bridge shadow: fsm, two-stage address/data pipe and held apb values
  logic [STATE_W-1:0] br_state    = ST_IDLE;
  logic [STATE_W-1:0] br_next     = ST_IDLE;
  logic [31:0]        addr_pipe1  = '0;
  logic [31:0]        addr_pipe2  = '0;
  logic [DW-1:0]      data_pipe1  = '0;
  logic [DW-1:0]      data_pipe2  = '0;
  logic               wr_flag_q   = 1'b0;
  logic [31:0]        hold_addr   = '0;
  logic [DW-1:0]      hold_wdata  = '0;
  logic               hold_write  = 1'b0;
  logic               hold_enable = 1'b0;
  logic               hold_ready  = 1'b0;
  logic [SEL_W-1:0]   hold_sel    = SEL_NONE;

  bridge_txn_t    pending_txns[$];
  bridge_result_t expected_results[$];
  bridge_txn_t    cur_txn;
  int             total_txns    = 0;
  int             txn_offered   = 0;
  int             txn_accepted  = 0;
  int             results_seen  = 0;
  int             fail_count    = 0;
  int             cycle_count   = 0;
  int             hold_left     = 0;
  logic           pressure_done = 1'b0;

  // advance the shadow bridge by one bus clock and return what it shows
  function automatic bridge_result_t predict_bridge_cycle(bridge_txn_t t);
    bridge_result_t r;
    logic           vld;
    logic [2:0]     sel;
    r   = '{default: '0};
    sel = SEL_NONE;
    if (!t.bus_reset_n) begin
      addr_pipe1 = '0;
      addr_pipe2 = '0;
      data_pipe1 = '0;
      data_pipe2 = '0;
      wr_flag_q  = 1'b0;
      br_state   = ST_IDLE;
    end else begin
      br_state         = br_next;
      addr_pipe2       = addr_pipe1;
      addr_pipe1       = t.address;
      data_pipe2       = data_pipe1;
      data_pipe1       = t.write_data;
      wr_flag_q        = t.write_enable;
      r.apb_address    = hold_addr;
      r.apb_write_data = hold_wdata;
      r.apb_write      = hold_write;
      r.apb_enable     = hold_enable;
      r.apb_select     = hold_sel;
      r.ready_out      = hold_ready;
      r.read_data      = t.peripheral_read_data;
      r.response       = RESP_OKAY;
    end

    // the top boundary counts as valid but selects nothing
    vld = t.bus_reset_n && t.ready_in && t.address >= SLV0_BASE && t.address <= WIN_TOP &&
          (t.transfer_type == HTRANS_NONSEQ || t.transfer_type == HTRANS_SEQ);
    if (t.bus_reset_n) begin
      if (t.address >= SLV0_BASE && t.address < SLV1_BASE) sel = SEL_S0;
      else if (t.address >= SLV1_BASE && t.address < SLV2_BASE) sel = SEL_S1;
      else if (t.address >= SLV2_BASE && t.address < WIN_TOP) sel = SEL_S2;
    end

    case (br_state)
      ST_IDLE, ST_RD_ACCESS: begin
        br_next = !vld ? ST_IDLE : (t.write_enable ? ST_WR_WAIT : ST_READ);
      end
      ST_WR_WAIT:       br_next = vld ? ST_WR_SETUP_PIPE : ST_WR_SETUP;
      ST_READ:          br_next = ST_RD_ACCESS;
      ST_WR_SETUP:      br_next = vld ? ST_WR_ACCESS_PIPE : ST_WR_ACCESS;
      ST_WR_SETUP_PIPE: br_next = ST_WR_ACCESS;
      ST_WR_ACCESS:     br_next = t.ready_in ? ST_IDLE : ST_WR_WAIT;
      default: begin
        if (!vld && wr_flag_q) br_next = ST_WR_SETUP;
        else if (vld && !wr_flag_q) br_next = ST_WR_SETUP_PIPE;
        else br_next = ST_READ;
      end
    endcase

    case (br_state)
      ST_IDLE, ST_RD_ACCESS: begin
        if (vld && !t.write_enable) begin
          hold_addr   = t.address;
          hold_write  = t.write_enable;
          hold_sel    = sel;
          hold_enable = 1'b0;
          hold_ready  = 1'b0;
        end else begin
          if (br_state == ST_IDLE) hold_addr = '0;
          else hold_sel = SEL_NONE;
          hold_enable = 1'b0;
          hold_ready  = 1'b1;
        end
      end
      ST_WR_WAIT: begin
        hold_addr   = addr_pipe1;
        hold_write  = 1'b1;
        hold_sel    = sel;
        hold_enable = 1'b0;
        hold_wdata  = vld ? data_pipe1 : t.write_data;
        hold_ready  = 1'b0;
      end
      ST_READ, ST_WR_SETUP_PIPE: begin
        hold_enable = 1'b1;
        hold_ready  = 1'b1;
      end
      ST_WR_ACCESS_PIPE: begin
        hold_addr   = addr_pipe2;
        hold_write  = t.write_enable;
        hold_sel    = sel;
        hold_enable = 1'b0;
        if (!vld && wr_flag_q) begin
          hold_wdata = t.write_data;
          hold_ready = 1'b0;
        end else begin
          hold_wdata = data_pipe2;
          hold_ready = 1'b1;
        end
      end
      ST_WR_ACCESS: begin
        if (!vld && wr_flag_q) hold_addr = '0;
        else hold_sel = SEL_NONE;
        hold_enable = 1'b0;
        hold_ready  = 1'b0;
      end
      default: ;  // write state keeps the held values
    endcase
    return r;
  endfunction

  function automatic bridge_txn_t make_txn(logic rn, logic rdy, logic [31:0] addr,
                                           logic [1:0] tt, logic wr,
                                           logic [DW-1:0] wd, logic [DW-1:0] rd);
    bridge_txn_t t;
    t.bus_reset_n          = rn;
    t.ready_in             = rdy;
    t.address              = addr;
    t.transfer_type        = tt;
    t.write_enable         = wr;
    t.write_data           = wd;
    t.peripheral_read_data = rd;
    return t;
  endfunction

  // mostly well-formed transfers into the window, the rest broken on purpose
  function automatic bridge_txn_t random_txn();
    bridge_txn_t t;
    int          roll;
    roll = $urandom_range(0, 99);
    t = make_txn(1'b1, 1'b1, '0, 2'($urandom_range(2, 3)), 1'($urandom_range(0, 1)),
                 DW'($urandom), DW'($urandom));
    case ($urandom_range(0, 2))
      0:       t.address = SLV0_BASE + $urandom_range(0, 32'h03FF_FFFF);
      1:       t.address = SLV1_BASE + $urandom_range(0, 32'h03FF_FFFF);
      default: t.address = SLV2_BASE + $urandom_range(0, 32'h03FF_FFFF);
    endcase
    if ($urandom_range(0, 49) == 0) t.address = WIN_TOP;
    if (roll < 3) begin
      t.bus_reset_n = 1'b0;
      t.address     = $urandom;
    end else if (roll >= 75) begin
      case ($urandom_range(0, 3))
        0:       t.ready_in = 1'b0;
        1:       t.transfer_type = 2'($urandom_range(0, 1));
        2:       t.address = $urandom;
        default: t.address = $urandom_range(0, 1) ? SLV0_BASE - $urandom_range(1, 16)
                                                  : WIN_TOP + $urandom_range(1, 16);
      endcase
    end
    return t;
  endfunction

  // idle phases rotate every hundred transactions: none, sender, receiver, both, none
  function automatic int send_idle_pct(int n);
    case ((n / 100) % 5)
      1:       return 69;
      3:       return 10;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int n);
    case ((n / 100) % 5)
      2:       return 69;
      3:       return 10;
      default: return 0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // driver: hold each transaction until accepted, then maybe idle
  always @(posedge clk) begin : drv
    logic        offer;
    bridge_txn_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_bridge_cycle(cur_txn));
        txn_accepted <= txn_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        offer = pending_txns.size() != 0 &&
                !($urandom_range(0, 99) < send_idle_pct(txn_offered));
        if (offer) begin
          nxt = pending_txns.pop_front();
          cur_txn              <= nxt;
          bus_reset_n          <= nxt.bus_reset_n;
          ready_in             <= nxt.ready_in;
          address              <= nxt.address;
          transfer_type        <= nxt.transfer_type;
          write_enable         <= nxt.write_enable;
          write_data           <= nxt.write_data;
          peripheral_read_data <= nxt.peripheral_read_data;
          txn_offered          <= txn_offered + 1;
        end
        in_valid <= offer;
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs up the bridge
  always @(posedge clk) begin : rcv
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && txn_offered >= HOLD_START) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else begin
      out_ready <= !($urandom_range(0, 99) < recv_stall_pct(txn_offered));
    end
  end

  // monitor: txn_accepted is the pre-edge count, so a same-edge push is never seen
  always @(posedge clk) begin : mon
    bridge_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (results_seen >= txn_accepted) begin
        $error("result with no expectation waiting: apb_address %0h", apb_address);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("apb_address", exp_r.apb_address, apb_address);
        check_field("apb_write_data", exp_r.apb_write_data, apb_write_data);
        check_field("apb_write", exp_r.apb_write, apb_write);
        check_field("apb_enable", exp_r.apb_enable, apb_enable);
        check_field("apb_select", exp_r.apb_select, apb_select);
        check_field("ready_out", exp_r.ready_out, ready_out);
        check_field("read_data", exp_r.read_data, read_data);
        check_field("response", exp_r.response, response);
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL ahb_to_apb_bridge_fsm_core");
      $finish;
    end
  end

  initial begin : stim
    int n;
    // directed: bus reset, each slave, window edges, every transfer type
    pending_txns.push_back(make_txn(1'b0, 1'b1, SLV0_BASE, HTRANS_NONSEQ, 1'b1, '1, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV0_BASE, HTRANS_NONSEQ, 1'b0, '0, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV1_BASE, HTRANS_SEQ, 1'b0, '1, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, WIN_TOP - 1, HTRANS_NONSEQ, 1'b0, '0,
                                    32'h1234_5678));
    pending_txns.push_back(make_txn(1'b1, 1'b1, WIN_TOP, HTRANS_NONSEQ, 1'b0, '0, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, WIN_TOP, HTRANS_SEQ, 1'b0, '0, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV0_BASE, HTRANS_NONSEQ, 1'b1, '1, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV1_BASE + 32'h03FF_FFFF, HTRANS_SEQ, 1'b1,
                                    '0, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV2_BASE, HTRANS_SEQ, 1'b1, 32'hA5A5_A5A5,
                                    '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV2_BASE, 2'h0, 1'b1, 32'h5A5A_5A5A, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV1_BASE, HTRANS_NONSEQ, 1'b1, '1, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV0_BASE, HTRANS_SEQ, 1'b0, '0, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV0_BASE, 2'h1, 1'b0, '1, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b0, SLV1_BASE, HTRANS_NONSEQ, 1'b1, '1, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV0_BASE - 1, HTRANS_NONSEQ, 1'b0, '0, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, 32'hFFFF_FFFF, HTRANS_SEQ, 1'b1, '1, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, 32'h0000_0000, HTRANS_NONSEQ, 1'b0, '0, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, WIN_TOP + 1, HTRANS_NONSEQ, 1'b1, '1, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV2_BASE + 4, HTRANS_NONSEQ, 1'b1,
                                    32'h0F0F_0F0F, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b0, SLV2_BASE + 8, HTRANS_SEQ, 1'b1,
                                    32'hF0F0_F0F0, '0));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV1_BASE + 8, HTRANS_SEQ, 1'b1, '1, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV0_BASE + 8, HTRANS_SEQ, 1'b0, '0, '0));
    pending_txns.push_back(make_txn(1'b0, 1'b0, 32'hFFFF_FFFF, 2'h3, 1'b1, '1, '1));
    pending_txns.push_back(make_txn(1'b1, 1'b1, SLV0_BASE, 2'h0, 1'b0, '0, '1));
    for (n = 0; n < RAND_TXNS; n++) pending_txns.push_back(random_txn());
    total_txns = pending_txns.size();

    do @(posedge clk); while (results_seen < total_txns);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS ahb_to_apb_bridge_fsm_core");
    end else begin
      $display("FAIL ahb_to_apb_bridge_fsm_core");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ahb_apb_pkg.sv
rtl/ahb_apb_in_reg.sv
rtl/ahb_apb_core.sv
rtl/ahb_apb_out_buf.sv
rtl/ahb_to_apb_bridge_fsm_core.sv
tb/sv/tb_top.sv
